// ===== rtl/vdlc_pkg.sv =====
// Shared types and constants for the squared Euclidean / cosine distance unit.
`timescale 1ns / 1ps
package vdlc_pkg;
    localparam int ELEM_W      = 16;
    localparam int DIST_W      = 43;
    localparam int DOT_W       = 44;
    localparam int NORM_W      = 42;
    localparam int CNT_W       = 11;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int MAX_DIM_DEF = 1024;
    localparam int PADDR_W     = 3;

    localparam logic [CNT_W-1:0]  DEF_LEN = 11'd128;
    localparam logic [DIST_W-1:0] ONE_Q30 = 43'h0_4000_0000;
    localparam logic              REG_MODE = 1'b0;
    localparam logic              REG_LEN  = 1'b1;
    localparam logic              MODE_L2  = 1'b0;
    localparam logic              MODE_COS = 1'b1;

    typedef struct packed {
        logic signed [ELEM_W-1:0] elem_a;
        logic signed [ELEM_W-1:0] elem_b;
    } t_in;

    typedef struct packed {
        logic [DIST_W-1:0] distance_value;
        logic              zero_norm;
    } t_out;

    typedef struct packed {
        logic                     mode;
        logic [DIST_W-1:0]        diff;
        logic signed [DOT_W-1:0]  dot;
        logic [NORM_W-1:0]        norm_a;
        logic [NORM_W-1:0]        norm_b;
    } t_job;

    typedef struct packed {
        logic [QCNT_W-1:0] cnt;
        logic              empty;
    } t_q_stat;
endpackage

// ===== rtl/vector_distance_l2_cosine.sv =====
// Top level of the streaming squared Euclidean / cosine distance unit.
`timescale 1ns / 1ps
// One element pair enters per cycle while input is not stalled; the front end
// registers each pair's products and then folds them into the running sums.
// With the back end idle, an L2 or zero-norm result passes the product
// registers, the queue and the back end's result register before it is offered.
// A cosine result instead works through the back end: shift-add for the norm
// product, 42 root digits, one compare and 30 quotient bits; the quotient
// is skipped when the similarity saturates. A two-entry queue holds finished
// vectors, so input keeps flowing while the back end works; input stalls
// whenever the queue, counting a vector about to enter it, is full.
module vector_distance_l2_cosine import vdlc_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in                i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out               o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic             r_mode;
    logic [CNT_W-1:0] r_len;
    logic             w_wr;
    logic             w_push, w_pop;
    t_job             w_fjob, w_qjob;
    t_q_stat          w_qstat;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_LEN) ? 32'(r_len) : 32'(r_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_L2;
            r_len  <= DEF_LEN;
        end else if (w_wr) begin
            if (paddr[2] == REG_MODE) begin
                r_mode <= pwdata[0];
            end else begin
                r_len <= pwdata[CNT_W-1:0];
            end
        end
    end

    vdlc_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_mode     (r_mode),
        .i_len      (r_len),
        .i_q_stat   (w_qstat),
        .o_push     (w_push),
        .o_job      (w_fjob)
    );

    vdlc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_stat  (w_qstat)
    );

    vdlc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_qjob),
        .i_q_stat    (w_qstat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |-> 32'(w_qstat.cnt) < QDEPTH)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("queue underflow");

    a_zero_norm_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.zero_norm |-> o_out_data.distance_value == ONE_Q30)
        else $error("zero norm result not one");

    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_mode == MODE_COS |->
            o_out_data.distance_value <= ONE_Q30 + ONE_Q30)
        else $error("cosine distance out of range");
`endif
endmodule

// ===== rtl/vdlc_front.sv =====
// Front end: accepts element pairs, accumulates sums, queues finished vectors.
`timescale 1ns / 1ps
module vdlc_front import vdlc_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    input  logic             i_mode,
    input  logic [CNT_W-1:0] i_len,
    input  t_q_stat          i_q_stat,
    output logic             o_push,
    output t_job             o_job
);
    logic [CNT_W-1:0]        w_len;
    logic                    w_last;
    logic                    w_accept;
    logic signed [ELEM_W:0]  w_d;
    logic signed [2*ELEM_W+1:0] w_dd;
    logic signed [2*ELEM_W-1:0] w_ab;
    logic signed [2*ELEM_W-1:0] w_aa;
    logic signed [2*ELEM_W-1:0] w_bb;

    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_p_vld, r_p_last, r_p_mode;
    logic [2*ELEM_W+1:0]     r_pdd;
    logic signed [2*ELEM_W-1:0] r_pab;
    logic [2*ELEM_W-1:0]     r_paa, r_pbb;
    logic [DIST_W-1:0]       r_diff, n_diff;
    logic signed [DOT_W-1:0] r_dot, n_dot;
    logic [NORM_W-1:0]       r_na, n_na, r_nb, n_nb;

    always_comb begin
        if (i_len == '0) begin
            w_len = CNT_W'(1);
        end else if (32'(i_len) > MAX_DIM) begin
            w_len = CNT_W'(MAX_DIM);
        end else begin
            w_len = i_len;
        end
    end

    assign w_last     = ({1'b0, r_cnt} + (CNT_W+1)'(1)) >= {1'b0, w_len};
    assign o_in_stall = ((QCNT_W+1)'(i_q_stat.cnt) + (QCNT_W+1)'(r_p_vld & r_p_last))
                        >= (QCNT_W+1)'(QDEPTH);
    assign w_accept   = i_in_valid & ~o_in_stall;

    assign w_d  = (ELEM_W+1)'(i_in_data.elem_a) - (ELEM_W+1)'(i_in_data.elem_b);
    assign w_dd = w_d * w_d;
    assign w_ab = i_in_data.elem_a * i_in_data.elem_b;
    assign w_aa = i_in_data.elem_a * i_in_data.elem_a;
    assign w_bb = i_in_data.elem_b * i_in_data.elem_b;

    always_comb begin
        n_cnt  = r_cnt;
        n_diff = r_diff + DIST_W'(r_pdd);
        n_dot  = r_dot + DOT_W'(r_pab);
        n_na   = r_na + NORM_W'(r_paa);
        n_nb   = r_nb + NORM_W'(r_pbb);
        if (w_accept) begin
            n_cnt = w_last ? '0 : r_cnt + CNT_W'(1);
        end
    end

    assign o_push        = r_p_vld & r_p_last;
    assign o_job.mode    = r_p_mode;
    assign o_job.diff    = n_diff;
    assign o_job.dot     = n_dot;
    assign o_job.norm_a  = n_na;
    assign o_job.norm_b  = n_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_p_vld  <= 1'b0;
            r_p_last <= 1'b0;
            r_diff   <= '0;
            r_dot    <= '0;
            r_na     <= '0;
            r_nb     <= '0;
        end else begin
            r_cnt    <= n_cnt;
            r_p_vld  <= w_accept;
            r_p_last <= w_accept & w_last;
            if (r_p_vld) begin
                if (r_p_last) begin
                    r_diff <= '0;
                    r_dot  <= '0;
                    r_na   <= '0;
                    r_nb   <= '0;
                end else begin
                    r_diff <= n_diff;
                    r_dot  <= n_dot;
                    r_na   <= n_na;
                    r_nb   <= n_nb;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_mode <= i_mode;
            r_pdd    <= w_dd;
            r_pab    <= w_ab;
            r_paa    <= w_aa;
            r_pbb    <= w_bb;
        end
    end
endmodule

// ===== rtl/vdlc_queue.sv =====
// Short job queue between the accumulating front end and the finishing back end.
`timescale 1ns / 1ps
module vdlc_queue import vdlc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);
    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_job        = r_mem[r_rp];
    assign o_stat.cnt   = r_cnt;
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (32'(r_wp) == QDEPTH - 1) ? '0 : r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (32'(r_rp) == QDEPTH - 1) ? '0 : r_rp + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule

// ===== rtl/vdlc_back.sv =====
// Back end: serial norm product, square root and division for cosine results; also returns L2 and zero-norm results.
`timescale 1ns / 1ps
module vdlc_back import vdlc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job    i_job,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_out    o_out_data
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SQRT = 6'b000100,
        S_CMP  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_bstate;

    localparam int PROD_W = 2 * NORM_W;

    t_bstate             r_st, n_st;
    logic [PROD_W-1:0]   r_acc, r_mc;
    logic [NORM_W-1:0]   r_mlt, r_root;
    logic [NORM_W+2:0]   r_rem;
    logic [DOT_W-1:0]    r_mag;
    logic                r_neg;
    logic [30:0]         r_q;
    logic [5:0]          r_cnt;
    t_out                r_res;

    logic [NORM_W+2:0]   w_rem_t, w_trial, w_rem_s;
    logic [30:0]         w_q;
    logic                w_div_ge;

    assign o_pop       = (r_st == S_IDLE) & ~i_q_stat.empty;
    assign o_out_valid = (r_st == S_OUT);
    assign o_out_data  = r_res;

    assign w_rem_t  = {r_rem[NORM_W:0], r_acc[PROD_W-1 -: 2]};
    assign w_trial  = (NORM_W+3)'({r_root, 2'b01});
    assign w_rem_s  = {r_rem[NORM_W+1:0], 1'b0};
    assign w_div_ge = w_rem_s >= (NORM_W+3)'(r_root);
    assign w_q      = {r_q[29:0], w_div_ge};

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    if (i_job.mode == MODE_L2 || i_job.norm_a == '0 || i_job.norm_b == '0) begin
                        n_st = S_OUT;
                    end else begin
                        n_st = S_MUL;
                    end
                end
            end
            S_MUL:  if (r_cnt == '0) n_st = S_SQRT;
            S_SQRT: if (r_cnt == '0) n_st = S_CMP;
            S_CMP:  n_st = (r_mag >= DOT_W'(r_root)) ? S_OUT : S_DIV;
            S_DIV:  if (r_cnt == '0) n_st = S_OUT;
            S_OUT:  if (!i_out_stall) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_acc <= '0;
                r_mc  <= PROD_W'(i_job.norm_a);
                r_mlt <= i_job.norm_b;
                r_cnt <= 6'(NORM_W - 1);
                r_neg <= i_job.dot[DOT_W-1];
                r_mag <= i_job.dot[DOT_W-1] ? DOT_W'(-i_job.dot) : DOT_W'(i_job.dot);
                r_rem <= '0;
                r_root <= '0;
                if (i_job.mode == MODE_L2) begin
                    r_res.distance_value <= i_job.diff;
                    r_res.zero_norm      <= 1'b0;
                end else begin
                    r_res.distance_value <= ONE_Q30;
                    r_res.zero_norm      <= 1'b1;
                end
            end
            S_MUL: begin
                if (r_mlt[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc  <= {r_mc[PROD_W-2:0], 1'b0};
                r_mlt <= {1'b0, r_mlt[NORM_W-1:1]};
                r_cnt <= (r_cnt == '0) ? 6'(NORM_W - 1) : r_cnt - 6'd1;
            end
            S_SQRT: begin
                if (w_rem_t >= w_trial) begin
                    r_rem  <= w_rem_t - w_trial;
                    r_root <= {r_root[NORM_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_t;
                    r_root <= {r_root[NORM_W-2:0], 1'b0};
                end
                r_acc <= {r_acc[PROD_W-3:0], 2'b00};
                r_cnt <= r_cnt - 6'd1;
            end
            S_CMP: begin
                r_rem <= (NORM_W+3)'(r_mag);
                r_q   <= '0;
                r_cnt <= 6'd29;
                r_res.zero_norm <= 1'b0;
                r_res.distance_value <= r_neg ? ONE_Q30 + ONE_Q30 : '0;
            end
            S_DIV: begin
                r_rem <= w_div_ge ? w_rem_s - (NORM_W+3)'(r_root) : w_rem_s;
                r_q   <= w_q;
                r_cnt <= r_cnt - 6'd1;
                r_res.distance_value <= r_neg ? ONE_Q30 + DIST_W'(w_q)
                                              : ONE_Q30 - DIST_W'(w_q);
            end
            S_OUT: begin
                r_cnt <= r_cnt;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end
endmodule
